FILE: sv/i2cq_pkg.sv
// Shared types, codes and widths of the I2C transaction queue sequencer.
`default_nettype none
package i2cq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 56;
	localparam int REQ_W       = 2;
	localparam int KIND_W      = 2;
	localparam int SLOT_W      = 4;
	localparam int STATUS_W    = 5;
	localparam int ADDR_W      = 7;
	localparam int BYTE_W      = 8;
	localparam int ECODE_W     = 4;
	localparam int LEN_W       = 2;
	localparam int LEVEL_W     = 5;

	// Request codes on the input tuser
	localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CMPL = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ERR  = 2'd2;

	// Result kinds on the output tuser
	localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CMD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 5'd0;
	localparam logic [STATUS_W-1:0] STATUS_REJECT = 5'd1;
	localparam logic [STATUS_W-1:0] STATUS_ERR    = 5'd2;

	localparam logic [LEN_W-1:0] LEN_STOP_ONLY = 2'd0;
	localparam logic [LEN_W-1:0] LEN_ONE       = 2'd1;
	localparam logic [LEN_W-1:0] LEN_TWO       = 2'd2;

	typedef struct packed {
		logic              reg_less;
		logic              is_write;
		logic [BYTE_W-1:0] write_data;
		logic [BYTE_W-1:0] reg_addr;
		logic [ADDR_W-1:0] dev_addr;
	} task_t;

	localparam int TASK_W = $bits(task_t);

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic                last;
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   cmd_addr;
		logic                cmd_read;
		logic                cmd_stop;
		logic [LEN_W-1:0]    cmd_len;
		logic [BYTE_W-1:0]   cmd_byte0;
		logic [BYTE_W-1:0]   cmd_byte1;
		logic [BYTE_W-1:0]   done_data;
		logic [LEVEL_W-1:0]  level;
	} result_t;

endpackage
`default_nettype wire

FILE: sv/i2c_transaction_queue_sequencer.sv
// Top level of the I2C transaction queue sequencer: ring storage, control, output register.
//
// Usage:
//   s_axis carries one request per transfer. tuser selects the request: enqueue a task,
//   bus transfer completed, or bus transfer error. tdata carries the task and event fields.
//   m_axis carries the results: acknowledges, commands for the I2C master and task
//   completions. tuser gives the result kind, tlast marks the last result of a request.
//   A request that is a stray bus event (no task on the bus) or an unused code gives no
//   result. A full queue rejects the enqueue with status 1 and changes nothing.
//   Timing: one request at a time. A request is taken in IDLE, then each result is loaded
//   from its own state; a result built from the task ring first passes a read state for
//   the registered read of the ring memory. An enqueue that starts an idle bus passes ACK,
//   RD_NEW and START; an error with a queued follow-up passes RD_OLD, DONE, STOP, RD_NEW
//   and START. The next request is taken once the last result sits in the output register.
//   Reset clears the ring pointers, the fill level, the bus flags and the output valid;
//   ring contents are not cleared, as only written slots are ever read.
//   A stall on m_axis holds the current result in the output register and holds the
//   sequencer at its next result; s_axis_tready stays low until the request is finished.
`default_nettype none
module i2c_transaction_queue_sequencer #(
	parameter int QUEUE_DEPTH = i2cq_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// dev_addr[6:0], reg_addr[14:7], write_data[22:15], is_write[23], reg_less[24],
	// read_data[32:25], error_code[36:33], zero fill[39:37]
	input  wire logic [i2cq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type[1:0]
	input  wire logic [i2cq_pkg::REQ_W-1:0]       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// task_slot[3:0], status[8:4], cmd_addr[15:9], cmd_read[16], cmd_stop[17],
	// cmd_len[19:18], cmd_byte0[27:20], cmd_byte1[35:28], done_data[43:36],
	// queue_level[48:44], zero fill[55:49]
	output logic [i2cq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// result_kind[1:0]
	output logic [i2cq_pkg::KIND_W-1:0]           m_axis_tuser,
	output logic                                  m_axis_tlast
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	i2cq_pkg::task_t   in_task;
	i2cq_pkg::task_t   wr_data, rd_data;
	i2cq_pkg::result_t res;
	logic              res_load, out_free;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;

	logic                                m_valid_q;
	logic [i2cq_pkg::OUT_TDATA_W-1:0]    m_data_q;
	logic [i2cq_pkg::KIND_W-1:0]         m_user_q;
	logic                                m_last_q;

	// Unpack the task fields of the input transfer
	assign in_task.dev_addr   = s_axis_tdata[6:0];
	assign in_task.reg_addr   = s_axis_tdata[14:7];
	assign in_task.write_data = s_axis_tdata[22:15];
	assign in_task.is_write   = s_axis_tdata[23];
	assign in_task.reg_less   = s_axis_tdata[24];

	i2cq_task_mem #(
		.DEPTH(QUEUE_DEPTH)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	i2cq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_req       (s_axis_tuser),
		.in_task      (in_task),
		.in_read_data (s_axis_tdata[32:25]),
		.in_error_code(s_axis_tdata[36:33]),
		.out_free     (out_free),
		.res_load     (res_load),
		.res          (res),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	// The output register is free when empty or when its result leaves this cycle
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Pack the result; hold it while the receiver stalls
	always_ff @(posedge clk) begin
		if (res_load) begin
			m_user_q <= res.kind;
			m_last_q <= res.last;
			m_data_q <= {7'd0, res.level, res.done_data, res.cmd_byte1, res.cmd_byte0,
				res.cmd_len, res.cmd_stop, res.cmd_read, res.cmd_addr, res.status, res.slot};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire

FILE: sv/i2cq_task_mem.sv
// Task ring storage: one write port, one registered read port.
`default_nettype none
module i2cq_task_mem #(
	parameter  int DEPTH = i2cq_pkg::DEF_QUEUE_DEPTH,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  wire i2cq_pkg::task_t wr_data,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output i2cq_pkg::task_t      rd_data
);

	i2cq_pkg::task_t mem_q [DEPTH];
	i2cq_pkg::task_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

FILE: sv/i2cq_ctrl.sv
// Queue pointers, bus ownership and the result sequencer of the task ring.
`default_nettype none
module i2cq_ctrl #(
	parameter  int QUEUE_DEPTH = i2cq_pkg::DEF_QUEUE_DEPTH,
	localparam int AW          = $clog2(QUEUE_DEPTH),
	localparam int LW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [i2cq_pkg::REQ_W-1:0]   in_req,
	input  wire i2cq_pkg::task_t              in_task,
	input  wire logic [i2cq_pkg::BYTE_W-1:0]  in_read_data,
	input  wire logic [i2cq_pkg::ECODE_W-1:0] in_error_code,
	input  wire logic                         out_free,
	output logic                              res_load,
	output i2cq_pkg::result_t                 res,
	output logic                              wr_en,
	output logic [AW-1:0]                     wr_addr,
	output i2cq_pkg::task_t                   wr_data,
	output logic                              rd_en,
	output logic [AW-1:0]                     rd_addr,
	input  wire i2cq_pkg::task_t              rd_data
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_ACK    = 7'b0000010,
		ST_RD_OLD = 7'b0000100,
		ST_DONE   = 7'b0001000,
		ST_STOP   = 7'b0010000,
		ST_RD_NEW = 7'b0100000,
		ST_START  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [AW-1:0] head_q, tail_q, slot_q;
	logic [LW-1:0] level_q;
	logic busy_q, await_q;
	logic start_q, stop_q, phase_q, reject_q, err_q;
	logic [i2cq_pkg::BYTE_W-1:0]  rdata_q;
	logic [i2cq_pkg::ECODE_W-1:0] ecode_q;

	logic accept, full, phase;
	logic [AW-1:0] head_inc, tail_inc;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (level_q == LW'(QUEUE_DEPTH));
	assign phase    = (in_req == i2cq_pkg::REQ_CMPL) && await_q;
	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	assign wr_en   = accept && (in_req == i2cq_pkg::REQ_ENQ) && !full;
	assign wr_addr = head_q;
	assign wr_data = in_task;
	assign rd_en   = state_q inside {ST_RD_OLD, ST_RD_NEW};
	assign rd_addr = (state_q == ST_RD_OLD) ? slot_q : tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			slot_q   <= '0;
			level_q  <= '0;
			busy_q   <= 1'b0;
			await_q  <= 1'b0;
			start_q  <= 1'b0;
			stop_q   <= 1'b0;
			phase_q  <= 1'b0;
			reject_q <= 1'b0;
			err_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_req == i2cq_pkg::REQ_ENQ) begin
							reject_q <= full;
							slot_q   <= head_q;
							stop_q   <= 1'b0;
							start_q  <= !full && !busy_q;
							if (!full) begin
								head_q  <= head_inc;
								level_q <= level_q + 1'b1;
								busy_q  <= 1'b1;
							end
							state_q <= ST_ACK;
						end else if (in_req inside {i2cq_pkg::REQ_CMPL, i2cq_pkg::REQ_ERR}
								&& busy_q) begin
							slot_q  <= tail_q;
							err_q   <= (in_req == i2cq_pkg::REQ_ERR);
							phase_q <= phase;
							await_q <= 1'b0;
							if (phase) begin
								start_q <= 1'b0;
								stop_q  <= 1'b0;
							end else begin
								// Retire the task; the next one starts if any wait
								tail_q  <= tail_inc;
								level_q <= level_q - 1'b1;
								busy_q  <= (level_q != LW'(1));
								start_q <= (level_q != LW'(1));
								stop_q  <= (in_req == i2cq_pkg::REQ_ERR);
							end
							state_q <= ST_RD_OLD;
						end
					end
				end
				ST_ACK: begin
					if (out_free) begin
						state_q <= start_q ? ST_RD_NEW : ST_IDLE;
					end
				end
				ST_RD_OLD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= stop_q ? ST_STOP : (start_q ? ST_RD_NEW : ST_IDLE);
					end
				end
				ST_STOP: begin
					if (out_free) begin
						state_q <= start_q ? ST_RD_NEW : ST_IDLE;
					end
				end
				ST_RD_NEW: begin
					state_q <= ST_START;
				end
				ST_START: begin
					if (out_free) begin
						await_q <= !rd_data.is_write && !rd_data.reg_less;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture the bus event payload for the completion result
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= in_read_data;
			ecode_q <= in_error_code;
		end
	end

	always_comb begin
		res       = '0;
		res.slot  = i2cq_pkg::SLOT_W'(slot_q);
		res.level = i2cq_pkg::LEVEL_W'(level_q);
		res_load  = 1'b0;
		case (state_q)
			ST_ACK: begin
				res_load = out_free;
				res.kind = i2cq_pkg::KIND_ACK;
				res.last = !start_q;
				if (reject_q) begin
					res.status = i2cq_pkg::STATUS_REJECT;
					res.slot   = '0;
				end
			end
			ST_DONE: begin
				res_load = out_free;
				res.last = !stop_q && !start_q;
				if (phase_q) begin
					res.kind     = i2cq_pkg::KIND_CMD;
					res.cmd_addr = rd_data.dev_addr;
					res.cmd_read = 1'b1;
					res.cmd_stop = 1'b1;
					res.cmd_len  = i2cq_pkg::LEN_ONE;
				end else begin
					res.kind = i2cq_pkg::KIND_DONE;
					if (err_q) begin
						res.status = i2cq_pkg::STATUS_ERR
							+ i2cq_pkg::STATUS_W'(ecode_q);
					end else if (!rd_data.is_write) begin
						res.done_data = rdata_q;
					end
				end
			end
			ST_STOP: begin
				res_load     = out_free;
				res.kind     = i2cq_pkg::KIND_CMD;
				res.last     = !start_q;
				res.cmd_addr = rd_data.dev_addr;
				res.cmd_stop = 1'b1;
				res.cmd_len  = i2cq_pkg::LEN_STOP_ONLY;
			end
			ST_START: begin
				res_load     = out_free;
				res.kind     = i2cq_pkg::KIND_CMD;
				res.last     = 1'b1;
				res.slot     = i2cq_pkg::SLOT_W'(tail_q);
				res.cmd_addr = rd_data.dev_addr;
				if (rd_data.is_write) begin
					res.cmd_stop = 1'b1;
					if (rd_data.reg_less) begin
						res.cmd_len   = i2cq_pkg::LEN_ONE;
						res.cmd_byte0 = rd_data.write_data;
					end else begin
						res.cmd_len   = i2cq_pkg::LEN_TWO;
						res.cmd_byte0 = rd_data.reg_addr;
						res.cmd_byte1 = rd_data.write_data;
					end
				end else if (!rd_data.reg_less) begin
					res.cmd_len   = i2cq_pkg::LEN_ONE;
					res.cmd_byte0 = rd_data.reg_addr;
				end else begin
					res.cmd_read = 1'b1;
					res.cmd_stop = 1'b1;
					res.cmd_len  = i2cq_pkg::LEN_ONE;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire
